>>> src/hcbd_pkg.sv
// Shared types and constants of the chunked body decoder.
package hcbd_pkg;

	localparam int unsigned BODY_LIMIT_W = 31;
	localparam int unsigned LINE_LIMIT_W = 17;
	localparam int unsigned COUNT_W      = 32;

	localparam logic [BODY_LIMIT_W-1:0] BODY_LIMIT_RESET = BODY_LIMIT_W'(8 << 20);
	localparam logic [LINE_LIMIT_W-1:0] LINE_LIMIT_RESET = LINE_LIMIT_W'(64 * 1024);

	// configuration register indexes
	localparam logic CFG_BODY_LIMIT = 1'b0;
	localparam logic CFG_LINE_LIMIT = 1'b1;

	// end status codes
	localparam logic [1:0] ST_RUNNING = 2'd0;
	localparam logic [1:0] ST_FINAL   = 2'd1;
	localparam logic [1:0] ST_CLOSED  = 2'd2;
	localparam logic [1:0] ST_LIMIT   = 2'd3;

	typedef struct packed {
		logic       begin_message;
		logic       input_closed;
		logic [7:0] data_byte;
	} hcbd_item_t;

	typedef struct packed {
		logic [1:0] end_status;
		logic       finished;
		logic       byte_valid;
		logic [7:0] body_byte;
	} hcbd_result_t;

endpackage

>>> src/hcbd_step.sv
// Decoder state and the per-byte next-state and result logic.
module hcbd_step
	import hcbd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    fire,
	input  hcbd_item_t              item,
	input  logic [BODY_LIMIT_W-1:0] body_limit,
	input  logic [LINE_LIMIT_W-1:0] line_limit,
	output hcbd_result_t            result
);

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_DATA,
		PH_TERM,
		PH_TRAILER,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		SP_BLANKS,
		SP_AFTER_ZERO,
		SP_AFTER_X,
		SP_DIGITS,
		SP_STOPPED
	} parse_step_t;

	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_ZERO = 8'h30;

	phase_t                    phase_q, phase_d;
	parse_step_t               step_q, step_d;
	logic [COUNT_W-1:0]        size_q, size_d;
	logic [COUNT_W-1:0]        left_q, left_d;
	logic [COUNT_W-1:0]        total_q, total_d;
	logic [LINE_LIMIT_W-1:0]   count_q, count_d;
	logic                      lwr_q, lwr_d;

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	// saturate once the top nibble is occupied
	function automatic logic [COUNT_W-1:0] add_digit(input logic [COUNT_W-1:0] v,
			input logic [3:0] d);
		logic [COUNT_W-1:0] r;
		if (v[COUNT_W-1 -: 4] != 4'd0) r = '1;
		else r = {v[COUNT_W-5:0], d};
		return r;
	endfunction

	logic [7:0]          c;
	logic [4:0]          hx;
	logic                over;
	logic                line_full;
	logic                line_end;
	logic                empty_line;
	logic [COUNT_W-1:0]  left_dec;

	always_comb begin
		c          = item.data_byte;
		hx         = hex_digit(c);
		result     = '0;
		line_end   = 1'b0;
		empty_line = 1'b0;
		over       = 1'b0;
		// start from a cleared state when a message begins
		if (item.begin_message) begin
			phase_d = PH_SIZE;
			step_d  = SP_BLANKS;
			size_d  = '0;
			left_d  = '0;
			total_d = '0;
			count_d = '0;
			lwr_d   = 1'b0;
		end else begin
			phase_d = phase_q;
			step_d  = step_q;
			size_d  = size_q;
			left_d  = left_q;
			total_d = total_q;
			count_d = count_q;
			lwr_d   = lwr_q;
		end
		line_full = count_d >= line_limit;
		left_dec  = left_d - COUNT_W'(1);

		if (phase_d == PH_DONE) begin
			// hold until the next message
		end else if (item.input_closed) begin
			over = (phase_d == PH_DATA || phase_d == PH_TERM) &&
				(total_d > COUNT_W'(body_limit));
			result.finished   = 1'b1;
			result.end_status = over ? ST_LIMIT : ST_CLOSED;
			phase_d           = PH_DONE;
		end else begin
			case (phase_d)
				PH_SIZE: begin
					if (c == CH_LF) begin
						line_end = 1'b1;
					end else begin
						case (step_d)
							SP_BLANKS: begin
								if (c inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D}) begin
									step_d = SP_BLANKS;
								end else if (c == CH_ZERO) begin
									step_d = SP_AFTER_ZERO;
								end else if (hx[4]) begin
									size_d = add_digit(size_d, hx[3:0]);
									step_d = SP_DIGITS;
								end else begin
									step_d = SP_STOPPED;
								end
							end
							SP_AFTER_ZERO, SP_AFTER_X, SP_DIGITS: begin
								if (step_d == SP_AFTER_ZERO && (c == 8'h78 || c == 8'h58)) begin
									step_d = SP_AFTER_X;
								end else if (hx[4]) begin
									size_d = add_digit(size_d, hx[3:0]);
									step_d = SP_DIGITS;
								end else begin
									step_d = SP_STOPPED;
								end
							end
							default: step_d = step_d;
						endcase
						if (line_full) begin
							line_end = 1'b1;
						end else begin
							count_d = count_d + LINE_LIMIT_W'(1);
							lwr_d   = c == CH_CR;
						end
					end
					if (line_end) begin
						count_d = '0;
						lwr_d   = 1'b0;
						if (size_d == '0) begin
							phase_d = PH_TRAILER;
						end else begin
							left_d  = size_d;
							phase_d = PH_DATA;
						end
						size_d = '0;
						step_d = SP_BLANKS;
					end
				end
				PH_DATA: begin
					if (total_d < COUNT_W'(body_limit)) begin
						result.body_byte  = c;
						result.byte_valid = 1'b1;
					end
					if (total_d != '1) total_d = total_d + COUNT_W'(1);
					left_d = left_dec;
					if (left_dec == '0) phase_d = PH_TERM;
				end
				PH_TERM: begin
					if (c == CH_LF || line_full) begin
						count_d = '0;
						lwr_d   = 1'b0;
						if (total_d > COUNT_W'(body_limit)) begin
							result.finished   = 1'b1;
							result.end_status = ST_LIMIT;
							phase_d           = PH_DONE;
						end else begin
							phase_d = PH_SIZE;
						end
					end else begin
						count_d = count_d + LINE_LIMIT_W'(1);
						lwr_d   = c == CH_CR;
					end
				end
				PH_TRAILER: begin
					if (c == CH_LF) begin
						empty_line = count_d == '0 || (count_d == LINE_LIMIT_W'(1) && lwr_d);
						count_d    = '0;
						lwr_d      = 1'b0;
						if (empty_line) begin
							result.finished   = 1'b1;
							result.end_status = ST_FINAL;
							phase_d           = PH_DONE;
						end
					end else if (line_full) begin
						count_d = '0;
						lwr_d   = 1'b0;
					end else begin
						count_d = count_d + LINE_LIMIT_W'(1);
						lwr_d   = c == CH_CR;
					end
				end
				default: phase_d = PH_DONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			step_q  <= SP_BLANKS;
			size_q  <= '0;
			left_q  <= '0;
			total_q <= '0;
			count_q <= '0;
			lwr_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			step_q  <= step_d;
			size_q  <= size_d;
			left_q  <= left_d;
			total_q <= total_d;
			count_q <= count_d;
			lwr_q   <= lwr_d;
		end
	end

	a_data_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != '0)
		else $error("data phase with no bytes left");

	a_status_with_finish: assert property (@(posedge clk) disable iff (!arst_n)
		result.finished == (result.end_status != ST_RUNNING))
		else $error("end status and finish disagree");

	a_byte_only_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		result.byte_valid |-> phase_q == PH_DATA && !result.finished)
		else $error("body byte outside data phase");

	a_done_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == PH_DONE && !item.begin_message |=> phase_q == PH_DONE)
		else $error("left finished state without a new message");

endmodule

>>> src/http_chunked_body_decoder_core.sv
// Top level of the chunked body decoder: input, configuration and result registers.
//
// Usage:
//   The slave stream carries one byte of an HTTP/1.1 chunked body per
//   transaction; tuser flags a closed connection or the start of a new
//   message. Every accepted byte yields exactly one master transaction:
//   tdata is the decoded body byte, tuser[0] says whether it is a body byte,
//   tuser[2:1] holds the end status and tlast marks the byte that ends
//   decoding of the body.
//   An accepted byte is held in the input register, and its result is
//   registered in the output register once the output is free to advance.
//   One byte per cycle is sustained unless the receiver stalls; the state
//   update is a single short step of logic between input and output registers.
//   When the receiver stalls, the output register holds its result, the
//   input register holds its byte or takes one if it is empty, and once it
//   is full tready stays low until the result is taken.
//   Reset clears both valid flags and returns the decoder to the start of a size
//   line with the limits at their defaults. Limits are written through the cfg
//   channel (always ready) only while idle; the user, not the block, ensures this.
module http_chunked_body_decoder_core
	import hcbd_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [7:0]              s_tdata,   // [7:0] data_byte
	input  logic [1:0]              s_tuser,   // [0] input_closed, [1] begin_message
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [7:0]              m_tdata,   // [7:0] body_byte
	output logic [2:0]              m_tuser,   // [0] byte_valid, [2:1] end_status
	output logic                    m_tlast,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_index,
	input  logic [BODY_LIMIT_W-1:0] cfg_data
);

	logic [BODY_LIMIT_W-1:0] body_limit_q;
	logic [LINE_LIMIT_W-1:0] line_limit_q;
	logic                    valid_s1;
	hcbd_item_t              item_s1;
	logic                    out_valid_q;
	hcbd_result_t            out_q;
	hcbd_result_t            result;
	logic                    advance;

	assign advance   = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_limit_q <= BODY_LIMIT_RESET;
			line_limit_q <= LINE_LIMIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BODY_LIMIT: body_limit_q <= cfg_data;
				CFG_LINE_LIMIT: line_limit_q <= cfg_data[LINE_LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= '{begin_message: s_tuser[1], input_closed: s_tuser[0],
				data_byte: s_tdata};
		end
	end

	hcbd_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (valid_s1 && advance),
		.item       (item_s1),
		.body_limit (body_limit_q),
		.line_limit (line_limit_q),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.body_byte;
	assign m_tuser  = {out_q.end_status, out_q.byte_valid};
	assign m_tlast  = out_q.finished;

endmodule
